// ===== rtl/rbm_pkg.sv =====
// Shared types and constants for the roaring bitmap block size measurer.
`timescale 1ns / 1ps
`default_nettype none
package rbm_pkg;

  localparam logic [16:0] MAX_CONTAINERS   = 17'd65536;
  localparam logic [16:0] ARRAY_LIMIT      = 17'd4096;
  localparam logic [16:0] OFFSET_THRESHOLD = 17'd4;

  localparam logic [31:0] COOKIE_NORUN   = 32'd12346;
  localparam logic [15:0] COOKIE_RUN     = 16'd12347;
  localparam logic [16:0] COUNT_SATURATE = 17'h1FFFF;
  localparam logic [34:0] BITSET_BYTES   = 35'd8192;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_COOKIE = 2'd1;
  localparam logic [1:0] ST_BAD_COUNT  = 2'd2;

  typedef enum logic [2:0] {
    PH_COOKIE     = 3'd0,
    PH_COUNT      = 3'd1,
    PH_DESC       = 3'd2,
    PH_NORUN_TAIL = 3'd3,
    PH_RUN_HDR    = 3'd4,
    PH_RUN_COUNT  = 3'd5,
    PH_RUN_SKIP   = 3'd6,
    PH_IDLE       = 3'd7
  } phase_t;

  typedef struct packed {
    logic [34:0] block_size;
    logic [16:0] container_count;
    logic        is_run_format;
    logic        is_normalized;
    logic [1:0]  status;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/roaring32_block_measure_unit.sv =====
// Top level: streaming size measurer for portable-format 32-bit roaring bitmap blocks.
//
//  channel | direction | ports                                   | request
//  in_     | input     | in_byte_value, in_start_block           | one stream byte
//  out_    | output    | out_block_size, out_container_count,    | one block summary
//          |           | out_is_run_format, out_is_normalized,   |
//          |           | out_status                              |
//
// One byte is taken each cycle while in_stall is low; the parse state and the result
// register are updated by one pass of logic; a summary is stored with its final byte.
// A result register plus one skid entry hold summaries while out_stall is high;
// in_stall rises only when the skid entry is full.
// rst_n is synchronous and clears the parse state and both result valid flags.
`timescale 1ns / 1ps
`default_nettype none
module roaring32_block_measure_unit #(
  parameter logic [16:0] MAX_CONTAINERS   = rbm_pkg::MAX_CONTAINERS,
  parameter logic [16:0] ARRAY_LIMIT      = rbm_pkg::ARRAY_LIMIT,
  parameter logic [16:0] OFFSET_THRESHOLD = rbm_pkg::OFFSET_THRESHOLD
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_start_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [34:0]      out_block_size,
  output logic [16:0]      out_container_count,
  output logic             out_is_run_format,
  output logic             out_is_normalized,
  output logic [1:0]       out_status
);

  rbm_pkg::phase_t  phase_r, phase_nxt;
  logic [31:0]      field_shift_r, field_shift_nxt;
  logic [2:0]       field_cnt_r, field_cnt_nxt;
  logic [31:0]      cookie_r, cookie_nxt;
  logic [16:0]      declared_r, declared_nxt;
  logic [16:0]      index_r, index_nxt;
  logic [34:0]      size_acc_r, size_acc_nxt;
  logic [34:0]      skip_r, skip_nxt;
  logic [34:0]      consumed_r, consumed_nxt;

  logic             emit;
  logic [1:0]       emit_status;
  logic [31:0]      gathered;
  logic [16:0]      card;
  logic [34:0]      offsets;
  logic [34:0]      run_hdr;
  rbm_pkg::result_t res;

  logic             in_acc;
  logic             res_valid;
  logic             out_take;
  logic             out_valid_r;
  logic             skid_valid_r;
  rbm_pkg::result_t out_r;
  rbm_pkg::result_t skid_r;

  assign in_acc    = in_valid & ~in_stall;
  assign res_valid = in_acc & emit;
  assign out_take  = out_valid_r & ~out_stall;

  always_comb begin
    phase_nxt       = phase_r;
    field_shift_nxt = field_shift_r;
    field_cnt_nxt   = field_cnt_r;
    cookie_nxt      = cookie_r;
    declared_nxt    = declared_r;
    index_nxt       = index_r;
    size_acc_nxt    = size_acc_r;
    skip_nxt        = skip_r;
    consumed_nxt    = consumed_r;
    emit            = 1'b0;
    emit_status     = rbm_pkg::ST_OK;
    gathered        = '0;
    card            = '0;
    offsets         = '0;
    run_hdr         = '0;

    if (in_start_block) begin
      phase_nxt       = rbm_pkg::PH_COOKIE;
      field_shift_nxt = '0;
      field_cnt_nxt   = '0;
      cookie_nxt      = '0;
      declared_nxt    = '0;
      index_nxt       = '0;
      size_acc_nxt    = '0;
      skip_nxt        = '0;
      consumed_nxt    = '0;
    end

    if (phase_nxt != rbm_pkg::PH_IDLE) begin
      consumed_nxt = consumed_nxt + 35'd1;
      gathered = field_shift_nxt |
                 ({24'd0, in_byte_value} << {field_cnt_nxt[1:0], 3'b000});
      case (phase_nxt)
        rbm_pkg::PH_COOKIE: begin
          field_shift_nxt = gathered;
          field_cnt_nxt   = field_cnt_nxt + 3'd1;
          if (field_cnt_nxt >= 3'd4) begin
            cookie_nxt      = gathered;
            field_shift_nxt = '0;
            field_cnt_nxt   = '0;
            if (gathered == rbm_pkg::COOKIE_NORUN) begin
              phase_nxt = rbm_pkg::PH_COUNT;
            end else if (gathered[15:0] == rbm_pkg::COOKIE_RUN) begin
              declared_nxt = {1'b0, gathered[31:16]} + 17'd1;
              if (declared_nxt > MAX_CONTAINERS) begin
                emit        = 1'b1;
                emit_status = rbm_pkg::ST_BAD_COUNT;
              end else begin
                offsets = (declared_nxt >= OFFSET_THRESHOLD) ?
                          {16'd0, declared_nxt, 2'b00} : 35'd0;
                run_hdr = {17'd0, ({1'b0, declared_nxt} + 18'd7) >> 3} +
                          {16'd0, declared_nxt, 2'b00} + offsets;
                skip_nxt  = run_hdr;
                index_nxt = '0;
                phase_nxt = rbm_pkg::PH_RUN_HDR;
              end
            end else begin
              emit        = 1'b1;
              emit_status = rbm_pkg::ST_BAD_COOKIE;
            end
          end
        end
        rbm_pkg::PH_COUNT: begin
          field_shift_nxt = gathered;
          field_cnt_nxt   = field_cnt_nxt + 3'd1;
          if (field_cnt_nxt >= 3'd4) begin
            field_shift_nxt = '0;
            field_cnt_nxt   = '0;
            if (gathered > {15'd0, MAX_CONTAINERS}) begin
              declared_nxt = (gathered > {15'd0, rbm_pkg::COUNT_SATURATE}) ?
                             rbm_pkg::COUNT_SATURATE : gathered[16:0];
              emit         = 1'b1;
              emit_status  = rbm_pkg::ST_BAD_COUNT;
            end else begin
              declared_nxt = gathered[16:0];
              if (gathered == 32'd0) begin
                emit = 1'b1;
              end else begin
                index_nxt    = '0;
                size_acc_nxt = '0;
                phase_nxt    = rbm_pkg::PH_DESC;
              end
            end
          end
        end
        rbm_pkg::PH_DESC: begin
          if (field_cnt_nxt[1:0] == 2'd2) begin
            field_shift_nxt = {24'd0, in_byte_value};
          end
          if (field_cnt_nxt[1:0] == 2'd3) begin
            card = {1'b0, in_byte_value, field_shift_nxt[7:0]} + 17'd1;
            size_acc_nxt = size_acc_nxt + ((card <= ARRAY_LIMIT) ?
                           {17'd0, card, 1'b0} : rbm_pkg::BITSET_BYTES);
            field_shift_nxt = '0;
            index_nxt       = index_nxt + 17'd1;
            if (index_nxt >= declared_nxt) begin
              offsets = (declared_nxt >= OFFSET_THRESHOLD) ?
                        {16'd0, declared_nxt, 2'b00} : 35'd0;
              skip_nxt  = offsets + size_acc_nxt;
              phase_nxt = rbm_pkg::PH_NORUN_TAIL;
            end
          end
          field_cnt_nxt = {1'b0, field_cnt_nxt[1:0] + 2'd1};
        end
        rbm_pkg::PH_NORUN_TAIL: begin
          if (skip_nxt != 35'd0) begin
            skip_nxt = skip_nxt - 35'd1;
          end
          if (skip_nxt == 35'd0) begin
            emit = 1'b1;
          end
        end
        rbm_pkg::PH_RUN_HDR: begin
          if (skip_nxt != 35'd0) begin
            skip_nxt = skip_nxt - 35'd1;
          end
          if (skip_nxt == 35'd0) begin
            field_shift_nxt = '0;
            field_cnt_nxt   = '0;
            phase_nxt       = rbm_pkg::PH_RUN_COUNT;
          end
        end
        rbm_pkg::PH_RUN_COUNT: begin
          field_shift_nxt = gathered;
          field_cnt_nxt   = field_cnt_nxt + 3'd1;
          if (field_cnt_nxt >= 3'd2) begin
            field_shift_nxt = '0;
            field_cnt_nxt   = '0;
            index_nxt       = index_nxt + 17'd1;
            if (gathered[15:0] == 16'd0) begin
              if (index_nxt >= declared_nxt) begin
                emit = 1'b1;
              end
            end else begin
              skip_nxt  = {17'd0, gathered[15:0], 2'b00};
              phase_nxt = rbm_pkg::PH_RUN_SKIP;
            end
          end
        end
        rbm_pkg::PH_RUN_SKIP: begin
          if (skip_nxt != 35'd0) begin
            skip_nxt = skip_nxt - 35'd1;
          end
          if (skip_nxt == 35'd0) begin
            if (index_nxt >= declared_nxt) begin
              emit = 1'b1;
            end else begin
              phase_nxt = rbm_pkg::PH_RUN_COUNT;
            end
          end
        end
        default: begin
          phase_nxt = rbm_pkg::PH_IDLE;
        end
      endcase
      if (emit) begin
        phase_nxt = rbm_pkg::PH_IDLE;
      end
    end

    res.block_size      = consumed_nxt;
    res.container_count = (emit_status == rbm_pkg::ST_BAD_COOKIE) ? 17'd0 : declared_nxt;
    res.is_run_format   = (emit_status != rbm_pkg::ST_BAD_COOKIE) &&
                          (cookie_nxt[15:0] == rbm_pkg::COOKIE_RUN);
    res.is_normalized   = (emit_status == rbm_pkg::ST_OK) &&
                          (cookie_nxt == rbm_pkg::COOKIE_NORUN) &&
                          !((declared_nxt != 17'd0) &&
                            (declared_nxt < OFFSET_THRESHOLD));
    res.status          = emit_status;
  end

  // advance parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= rbm_pkg::PH_COOKIE;
      field_shift_r <= '0;
      field_cnt_r   <= '0;
      cookie_r      <= '0;
      declared_r    <= '0;
      index_r       <= '0;
      size_acc_r    <= '0;
      skip_r        <= '0;
      consumed_r    <= '0;
    end else if (in_acc) begin
      phase_r       <= phase_nxt;
      field_shift_r <= field_shift_nxt;
      field_cnt_r   <= field_cnt_nxt;
      cookie_r      <= cookie_nxt;
      declared_r    <= declared_nxt;
      index_r       <= index_nxt;
      size_acc_r    <= size_acc_nxt;
      skip_r        <= skip_nxt;
      consumed_r    <= consumed_nxt;
    end
  end

  // hold results in the output register and the skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign in_stall            = skid_valid_r;
  assign out_valid           = out_valid_r;
  assign out_block_size      = out_r.block_size;
  assign out_container_count = out_r.container_count;
  assign out_is_run_format   = out_r.is_run_format;
  assign out_is_normalized   = out_r.is_normalized;
  assign out_status          = out_r.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> phase_r == rbm_pkg::PH_IDLE)
    else $error("parser not idle after a block summary");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == rbm_pkg::PH_IDLE && !in_start_block) |-> !res_valid)
    else $error("summary produced while idle");

  a_bad_cookie_size: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == rbm_pkg::ST_BAD_COOKIE) |->
      (res.block_size == 35'd4 && res.container_count == 17'd0))
    else $error("bad cookie summary has wrong size or count");

endmodule
`default_nettype wire
